FILE: hw/rtl/coprop_pkg.sv
// Shared types, constants and lookup functions for the circular-orbit state block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package coprop_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ATAN_LEN     = 40;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    localparam int PH_LAT     = 2;
    localparam int CORDIC_LAT = CORDIC_N + 2;
    localparam int FRAME_LAT  = 5;
    localparam int PIPE_LAT   = PH_LAT + CORDIC_LAT + FRAME_LAT;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    typedef enum logic [2:0] {
        REG_RADIUS,
        REG_RATE,
        REG_PHASE,
        REG_NODE,
        REG_TILT,
        REG_SUN_X,
        REG_SUN_Y,
        REG_SUN_Z
    } t_reg_idx;

    localparam logic signed [31:0] Q30         = 32'sh4000_0000;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [63:0]        TWO_PI_Q61  = 64'hC90F_DAA2_2168_C235;
    localparam logic [19:0]        US_PER_S    = 20'd1000000;

    localparam logic [35:0] RST_RADIUS = 36'd6923137000;
    localparam logic [47:0] RST_RATE   = 48'd3217900000;
    localparam logic [31:0] RST_PHASE  = 32'd2041650000;
    localparam logic [31:0] RST_NODE   = 32'd2707420000;
    localparam logic [31:0] RST_TILT   = 32'd1164090000;

    typedef struct packed {
        logic [35:0]        radius;
        logic [47:0]        rate;
        logic [31:0]        phase;
        logic [31:0]        node;
        logic [31:0]        tilt;
        logic signed [31:0] sun_x;
        logic signed [31:0] sun_y;
        logic signed [31:0] sun_z;
    } t_cfg;

    function automatic logic [31:0] atan_turn(input int k);
        case (k)
            0:  return 32'h20000000;
            1:  return 32'h12E4051E;
            2:  return 32'h09FB385B;
            3:  return 32'h051111D4;
            4:  return 32'h028B0D43;
            5:  return 32'h0145D7E1;
            6:  return 32'h00A2F61E;
            7:  return 32'h00517C55;
            8:  return 32'h0028BE53;
            9:  return 32'h00145F2F;
            10: return 32'h000A2F98;
            11: return 32'h000517CC;
            12: return 32'h00028BE6;
            13: return 32'h000145F3;
            14: return 32'h0000A2FA;
            15: return 32'h0000517D;
            16: return 32'h000028BE;
            17: return 32'h0000145F;
            18: return 32'h00000A30;
            19: return 32'h00000518;
            20: return 32'h0000028C;
            21: return 32'h00000146;
            22: return 32'h000000A3;
            23: return 32'h00000051;
            24: return 32'h00000029;
            25: return 32'h00000014;
            26: return 32'h0000000A;
            27: return 32'h00000005;
            28: return 32'h00000003;
            29: return 32'h00000001;
            30: return 32'h00000001;
            default: return 32'h00000000;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/coprop_regs.sv
// APB configuration register file: orbit, angle and sun direction settings.
// Depends on coprop_pkg.
`default_nettype none

module coprop_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [coprop_pkg::ADDR_W-1:0] paddr,
    input  wire logic [coprop_pkg::DATA_W-1:0] pwdata,
    output logic      [coprop_pkg::DATA_W-1:0] prdata,
    output logic                               pready,
    output coprop_pkg::t_cfg                   o_cfg
);
    import coprop_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    function automatic logic signed [31:0] clamp_sun(input logic [31:0] v);
        if ($signed(v) > Q30) begin
            return Q30;
        end else if ($signed(v) < -Q30) begin
            return -Q30;
        end
        return $signed(v);
    endfunction

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius <= RST_RADIUS;
            r_cfg.rate   <= RST_RATE;
            r_cfg.phase  <= RST_PHASE;
            r_cfg.node   <= RST_NODE;
            r_cfg.tilt   <= RST_TILT;
            r_cfg.sun_x  <= Q30;
            r_cfg.sun_y  <= '0;
            r_cfg.sun_z  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_RADIUS: r_cfg.radius <= pwdata[35:0];
                REG_RATE:   r_cfg.rate   <= pwdata[47:0];
                REG_PHASE:  r_cfg.phase  <= pwdata[31:0];
                REG_NODE:   r_cfg.node   <= pwdata[31:0];
                REG_TILT:   r_cfg.tilt   <= pwdata[31:0];
                REG_SUN_X:  r_cfg.sun_x  <= clamp_sun(pwdata[31:0]);
                REG_SUN_Y:  r_cfg.sun_y  <= clamp_sun(pwdata[31:0]);
                REG_SUN_Z:  r_cfg.sun_z  <= clamp_sun(pwdata[31:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RADIUS: prdata = {28'd0, r_cfg.radius};
            REG_RATE:   prdata = {16'd0, r_cfg.rate};
            REG_PHASE:  prdata = {32'd0, r_cfg.phase};
            REG_NODE:   prdata = {32'd0, r_cfg.node};
            REG_TILT:   prdata = {32'd0, r_cfg.tilt};
            REG_SUN_X:  prdata = {{32{r_cfg.sun_x[31]}}, r_cfg.sun_x};
            REG_SUN_Y:  prdata = {{32{r_cfg.sun_y[31]}}, r_cfg.sun_y};
            REG_SUN_Z:  prdata = {{32{r_cfg.sun_z[31]}}, r_cfg.sun_z};
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/coprop_cordic.sv
// Pipelined CORDIC rotation: one step per stage, angle in turns to cosine and sine (Q1.30).
// Depends on coprop_pkg for the step count, gain and arctangent table.
`default_nettype none

module coprop_cordic (
    input  wire logic          i_clk,
    input  wire logic [31:0]   i_ang,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    import coprop_pkg::*;

    localparam int XW = 34;
    localparam logic signed [XW-1:0] LIM  = XW'(Q30);
    localparam logic signed [XW-1:0] HALF = XW'(Q30) <<< 1;

    logic signed [XW-1:0] r_x [0:CORDIC_N];
    logic signed [XW-1:0] r_y [0:CORDIC_N];
    logic signed [XW-1:0] r_z [0:CORDIC_N];
    logic                 r_flip [0:CORDIC_N];

    logic signed [XW-1:0] n_z0;
    logic                 n_flip0;
    logic signed [XW-1:0] n_xf;
    logic signed [XW-1:0] n_yf;
    logic signed [31:0]   r_cos;
    logic signed [31:0]   r_sin;

    // fold into a half turn about zero
    always_comb begin
        n_z0    = $signed({{(XW-32){i_ang[31]}}, i_ang});
        n_flip0 = 1'b0;
        if (n_z0 > LIM) begin
            n_z0    = n_z0 - HALF;
            n_flip0 = 1'b1;
        end else if (n_z0 < -LIM) begin
            n_z0    = n_z0 + HALF;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= CORDIC_GAIN;
        r_y[0]    <= '0;
        r_z[0]    <= n_z0;
        r_flip[0] <= n_flip0;
    end

    for (genvar k = 0; k < CORDIC_N; k++) begin : g_step
        logic signed [XW-1:0] atan_k;
        assign atan_k = $signed({{(XW-32){1'b0}}, atan_turn(k)});

        always_ff @(posedge i_clk) begin
            if (!r_z[k][XW-1]) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - atan_k;
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + atan_k;
            end
            r_flip[k+1] <= r_flip[k];
        end
    end

    always_comb begin
        n_xf = r_flip[CORDIC_N] ? -r_x[CORDIC_N] : r_x[CORDIC_N];
        n_yf = r_flip[CORDIC_N] ? -r_y[CORDIC_N] : r_y[CORDIC_N];
    end

    always_ff @(posedge i_clk) begin
        r_cos <= (n_xf > LIM) ? Q30 : ((n_xf < -LIM) ? -Q30 : n_xf[31:0]);
        r_sin <= (n_yf > LIM) ? Q30 : ((n_yf < -LIM) ? -Q30 : n_yf[31:0]);
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

`default_nettype wire

FILE: hw/rtl/coprop_speed.sv
// Orbital speed pipeline: rate to rad/s, times radius, in partial products of up to 32x32 bits.
// Depends on coprop_pkg for the 2*pi and microsecond constants.
`default_nettype none

module coprop_speed (
    input  wire logic [35:0] i_radius,
    input  wire logic [47:0] i_rate,
    input  wire logic        i_clk,
    output logic      [63:0] o_spd
);
    import coprop_pkg::*;

    logic [51:0]  r_ml;
    logic [35:0]  r_mh;
    logic [67:0]  n_m;
    logic [63:0]  r_w0;
    logic [63:0]  r_ll, r_lh, r_hl, r_hh;
    logic [127:0] n_full;
    logic [63:0]  r_w;
    logic [63:0]  r_pll, r_plh;
    logic [35:0]  r_phl, r_phh;
    logic [99:0]  n_p;
    logic [63:0]  r_spd;

    always_comb begin
        n_m    = {16'd0, r_ml} + {r_mh, 32'd0};
        n_full = {64'd0, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0} + {r_hh, 64'd0};
        n_p    = {36'd0, r_pll} + {4'd0, r_plh, 32'd0} + {32'd0, r_phl, 32'd0}
               + {r_phh, 64'd0};
    end

    always_ff @(posedge i_clk) begin
        r_ml  <= i_rate[31:0] * US_PER_S;
        r_mh  <= i_rate[47:32] * US_PER_S;
        r_w0  <= n_m[67:4];
        r_ll  <= r_w0[31:0] * TWO_PI_Q61[31:0];
        r_lh  <= r_w0[31:0] * TWO_PI_Q61[63:32];
        r_hl  <= r_w0[63:32] * TWO_PI_Q61[31:0];
        r_hh  <= r_w0[63:32] * TWO_PI_Q61[63:32];
        r_w   <= n_full[127:64];
        r_pll <= i_radius[31:0] * r_w[31:0];
        r_plh <= i_radius[31:0] * r_w[63:32];
        r_phl <= i_radius[35:32] * r_w[31:0];
        r_phh <= i_radius[35:32] * r_w[63:32];
        r_spd <= n_p[99:36];
    end

    assign o_spd = r_spd;

endmodule

`default_nettype wire

FILE: hw/rtl/coprop_frame.sv
// Frame pipeline: local axes from the sines and cosines, then scaled position,
// velocity and sun projections with rounding and saturation. Depends on coprop_pkg.
`default_nettype none

module coprop_frame (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_cu,
    input  wire logic signed [31:0] i_su,
    input  wire logic signed [31:0] i_cr,
    input  wire logic signed [31:0] i_sr,
    input  wire logic signed [31:0] i_ci,
    input  wire logic signed [31:0] i_si,
    input  wire logic        [35:0] i_radius,
    input  wire logic        [63:0] i_spd,
    input  wire logic signed [31:0] i_sun_x,
    input  wire logic signed [31:0] i_sun_y,
    input  wire logic signed [31:0] i_sun_z,
    output logic signed      [36:0] o_pos_x,
    output logic signed      [36:0] o_pos_y,
    output logic signed      [36:0] o_pos_z,
    output logic signed      [24:0] o_vel_x,
    output logic signed      [24:0] o_vel_y,
    output logic signed      [24:0] o_vel_z,
    output logic signed      [31:0] o_sun_radial,
    output logic signed      [31:0] o_sun_along_track,
    output logic signed      [31:0] o_sun_normal
);
    import coprop_pkg::*;

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return p[61:30];
    endfunction

    function automatic logic signed [32:0] ext(input logic signed [31:0] a);
        return $signed({a[31], a});
    endfunction

    function automatic logic [31:0] mag(input logic signed [32:0] a);
        logic [32:0] t;
        t = a[32] ? 33'(-a) : 33'(a);
        return t[31:0];
    endfunction

    function automatic logic signed [36:0] sat_pos(input logic neg, input logic [63:0] lo,
                                                   input logic [35:0] hi);
        logic [67:0] s;
        logic [37:0] q;
        s = {4'd0, lo} + {hi, 32'd0} + 68'd536870912;
        q = s[67:30];
        if (neg) begin
            return (q > 38'h10_0000_0000) ? 37'h10_0000_0000 : 37'(38'd0 - q);
        end
        return (q > 38'h0F_FFFF_FFFF) ? 37'h0F_FFFF_FFFF : q[36:0];
    endfunction

    function automatic logic signed [24:0] sat_vel(input logic neg, input logic [63:0] lo,
                                                   input logic [63:0] hi);
        logic [95:0] s;
        logic [44:0] q;
        s = {32'd0, lo} + {hi, 32'd0} + 96'h4_0000_0000_0000;
        q = s[95:51];
        if (neg) begin
            return (q > 45'h100_0000) ? 25'h100_0000 : 25'(45'd0 - q);
        end
        return (q > 45'hFF_FFFF) ? 25'hFF_FFFF : q[24:0];
    endfunction

    function automatic logic signed [31:0] sun_round(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input logic signed [63:0] c);
        logic signed [65:0] d;
        logic signed [35:0] q;
        d = 66'(a) + 66'(b) + 66'(c) + 66'sd536870912;
        q = d[65:30];
        if (q > 36'sd1073741824) begin
            return Q30;
        end else if (q < -36'sd1073741824) begin
            return -Q30;
        end
        return q[31:0];
    endfunction

    // stage 1
    logic signed [31:0] r_a, r_b, r_cucr, r_cusr, r_sucr, r_susr;
    logic signed [31:0] r_fz1, r_gz1, r_hx1, r_hy1, r_hz1, r_sr1, r_cr1;
    // stage 2
    logic signed [31:0] r_asr, r_acr, r_bsr, r_bcr;
    logic signed [31:0] r_cucr2, r_cusr2, r_sucr2, r_susr2;
    logic signed [31:0] r_fz2, r_gz2, r_hx2, r_hy2, r_hz2;
    // stage 3
    logic signed [32:0] r_f [0:2];
    logic signed [32:0] r_g [0:2];
    logic signed [32:0] r_h [0:2];
    // stage 4
    logic signed [31:0] w_sun [0:2];
    logic        [63:0] r_pf_lo [0:2];
    logic        [35:0] r_pf_hi [0:2];
    logic        [63:0] r_pg_lo [0:2];
    logic        [63:0] r_pg_hi [0:2];
    logic               r_nf [0:2];
    logic               r_ng [0:2];
    logic signed [63:0] r_sf [0:2];
    logic signed [63:0] r_sg [0:2];
    logic signed [63:0] r_sh [0:2];
    // stage 5
    logic signed [36:0] r_pos [0:2];
    logic signed [24:0] r_vel [0:2];
    logic signed [31:0] r_sun [0:2];

    assign w_sun[0] = i_sun_x;
    assign w_sun[1] = i_sun_y;
    assign w_sun[2] = i_sun_z;

    always_ff @(posedge i_clk) begin
        r_a    <= qmul(i_su, i_ci);
        r_b    <= qmul(i_cu, i_ci);
        r_cucr <= qmul(i_cu, i_cr);
        r_cusr <= qmul(i_cu, i_sr);
        r_sucr <= qmul(i_su, i_cr);
        r_susr <= qmul(i_su, i_sr);
        r_fz1  <= qmul(i_su, i_si);
        r_gz1  <= qmul(i_cu, i_si);
        r_hx1  <= qmul(i_sr, i_si);
        r_hy1  <= -qmul(i_cr, i_si);
        r_hz1  <= i_ci;
        r_sr1  <= i_sr;
        r_cr1  <= i_cr;

        r_asr   <= qmul(r_a, r_sr1);
        r_acr   <= qmul(r_a, r_cr1);
        r_bsr   <= qmul(r_b, r_sr1);
        r_bcr   <= qmul(r_b, r_cr1);
        r_cucr2 <= r_cucr;
        r_cusr2 <= r_cusr;
        r_sucr2 <= r_sucr;
        r_susr2 <= r_susr;
        r_fz2   <= r_fz1;
        r_gz2   <= r_gz1;
        r_hx2   <= r_hx1;
        r_hy2   <= r_hy1;
        r_hz2   <= r_hz1;

        r_f[0] <= ext(r_cucr2) - ext(r_asr);
        r_f[1] <= ext(r_cusr2) + ext(r_acr);
        r_f[2] <= ext(r_fz2);
        r_g[0] <= -ext(r_sucr2) - ext(r_bsr);
        r_g[1] <= -ext(r_susr2) + ext(r_bcr);
        r_g[2] <= ext(r_gz2);
        r_h[0] <= ext(r_hx2);
        r_h[1] <= ext(r_hy2);
        r_h[2] <= ext(r_hz2);

        for (int c = 0; c < 3; c++) begin
            r_pf_lo[c] <= i_radius[31:0] * mag(r_f[c]);
            r_pf_hi[c] <= i_radius[35:32] * mag(r_f[c]);
            r_pg_lo[c] <= i_spd[31:0] * mag(r_g[c]);
            r_pg_hi[c] <= i_spd[63:32] * mag(r_g[c]);
            r_nf[c]    <= r_f[c][32];
            r_ng[c]    <= r_g[c][32];
            r_sf[c]    <= r_f[c] * w_sun[c];
            r_sg[c]    <= r_g[c] * w_sun[c];
            r_sh[c]    <= r_h[c] * w_sun[c];
        end

        for (int c = 0; c < 3; c++) begin
            r_pos[c] <= sat_pos(r_nf[c], r_pf_lo[c], r_pf_hi[c]);
            r_vel[c] <= sat_vel(r_ng[c], r_pg_lo[c], r_pg_hi[c]);
        end
        r_sun[0] <= sun_round(r_sf[0], r_sf[1], r_sf[2]);
        r_sun[1] <= sun_round(r_sg[0], r_sg[1], r_sg[2]);
        r_sun[2] <= sun_round(r_sh[0], r_sh[1], r_sh[2]);
    end

    assign o_pos_x           = r_pos[0];
    assign o_pos_y           = r_pos[1];
    assign o_pos_z           = r_pos[2];
    assign o_vel_x           = r_vel[0];
    assign o_vel_y           = r_vel[1];
    assign o_vel_z           = r_vel[2];
    assign o_sun_radial      = r_sun[0];
    assign o_sun_along_track = r_sun[1];
    assign o_sun_normal      = r_sun[2];

endmodule

`default_nettype wire

FILE: hw/rtl/circular_orbit_state_and_sun_lvlh.sv
// Circular-orbit position, velocity and local-frame sun direction per time stamp.
// Instantiates coprop_regs, coprop_cordic, coprop_speed and coprop_frame; uses coprop_pkg.
//
// A time stamp is taken on any clock edge with start high; busy is always low, so one
// transaction per cycle is accepted. Each result appears on the o_ ports with o_valid
// high for a single cycle, after the two phase stages, the one-step-per-stage CORDIC
// pipeline with its input and output registers, and the five frame stages. Results
// come out in order and cannot be held off. Write the APB registers (8-byte stride)
// only while no transaction is in flight.
`default_nettype none

module circular_orbit_state_and_sun_lvlh (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [47:0]                   i_time_us,
    output logic                               o_valid,
    output logic signed [36:0]                 o_pos_x,
    output logic signed [36:0]                 o_pos_y,
    output logic signed [36:0]                 o_pos_z,
    output logic signed [24:0]                 o_vel_x,
    output logic signed [24:0]                 o_vel_y,
    output logic signed [24:0]                 o_vel_z,
    output logic signed [31:0]                 o_sun_radial,
    output logic signed [31:0]                 o_sun_along_track,
    output logic signed [31:0]                 o_sun_normal,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [coprop_pkg::ADDR_W-1:0] paddr,
    input  wire logic [coprop_pkg::DATA_W-1:0] pwdata,
    output logic      [coprop_pkg::DATA_W-1:0] prdata,
    output logic                               pready
);
    import coprop_pkg::*;

    t_cfg               w_cfg;
    logic [PIPE_LAT-1:0] r_vld;
    logic [63:0]        r_pll;
    logic [31:0]        r_plh, r_phl;
    logic [47:0]        n_plh, n_phl;
    logic [31:0]        r_u;
    logic signed [31:0] w_cu, w_su, w_cr, w_sr, w_ci, w_si;
    logic [63:0]        w_spd;

    assign busy = 1'b0;

    coprop_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], start && !busy};
        end
    end

    // phase: low 64 bits of rate * time, upper word only
    always_comb begin
        n_plh = w_cfg.rate[31:0] * i_time_us[47:32];
        n_phl = w_cfg.rate[47:32] * i_time_us[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_pll <= w_cfg.rate[31:0] * i_time_us[31:0];
        r_plh <= n_plh[31:0];
        r_phl <= n_phl[31:0];
        r_u   <= w_cfg.phase + r_pll[63:32] + r_plh + r_phl;
    end

    coprop_cordic u_cordic_u (
        .i_clk (i_clk),
        .i_ang (r_u),
        .o_cos (w_cu),
        .o_sin (w_su)
    );

    coprop_cordic u_cordic_node (
        .i_clk (i_clk),
        .i_ang (w_cfg.node),
        .o_cos (w_cr),
        .o_sin (w_sr)
    );

    coprop_cordic u_cordic_tilt (
        .i_clk (i_clk),
        .i_ang (w_cfg.tilt),
        .o_cos (w_ci),
        .o_sin (w_si)
    );

    coprop_speed u_speed (
        .i_radius (w_cfg.radius),
        .i_rate   (w_cfg.rate),
        .i_clk    (i_clk),
        .o_spd    (w_spd)
    );

    coprop_frame u_frame (
        .i_clk             (i_clk),
        .i_cu              (w_cu),
        .i_su              (w_su),
        .i_cr              (w_cr),
        .i_sr              (w_sr),
        .i_ci              (w_ci),
        .i_si              (w_si),
        .i_radius          (w_cfg.radius),
        .i_spd             (w_spd),
        .i_sun_x           (w_cfg.sun_x),
        .i_sun_y           (w_cfg.sun_y),
        .i_sun_z           (w_cfg.sun_z),
        .o_pos_x           (o_pos_x),
        .o_pos_y           (o_pos_y),
        .o_pos_z           (o_pos_z),
        .o_vel_x           (o_vel_x),
        .o_vel_y           (o_vel_y),
        .o_vel_z           (o_vel_z),
        .o_sun_radial      (o_sun_radial),
        .o_sun_along_track (o_sun_along_track),
        .o_sun_normal      (o_sun_normal)
    );

    assign o_valid = r_vld[PIPE_LAT-1];

endmodule

`default_nettype wire

FILE: hw/rtl/coprop_checker.sv
// Port-level checks for the circular-orbit block, bound to its top level.
// Depends on coprop_pkg for the pipeline latency.
`default_nettype none

module coprop_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic        pready,
    input wire logic [31:0] o_sun_radial,
    input wire logic [31:0] o_sun_along_track,
    input wire logic [31:0] o_sun_normal
);
    import coprop_pkg::*;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##PIPE_LAT o_valid)
        else $error("transaction produced no result");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result without transaction");

    a_sun_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_sun_radial) <= 32'sd1073741824
                  && $signed(o_sun_radial) >= -32'sd1073741824
                  && $signed(o_sun_along_track) <= 32'sd1073741824
                  && $signed(o_sun_along_track) >= -32'sd1073741824
                  && $signed(o_sun_normal) <= 32'sd1073741824
                  && $signed(o_sun_normal) >= -32'sd1073741824))
        else $error("sun component out of range");

    a_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && !busy)
        else $error("block stalled");

endmodule

bind circular_orbit_state_and_sun_lvlh coprop_checker u_checker (.*);

`default_nettype wire
